>>> rtl/core/i2cm_pkg.sv
package i2cm_pkg;

    // widths of the payload fields, line positions and bit counter
    localparam int LEVELS_WIDTH    = 32;
    localparam int TIME_WIDTH      = 32;
    localparam int BYTE_WIDTH      = 8;
    localparam int LINE_POS_WIDTH  = 5;
    localparam int BIT_COUNT_WIDTH = 4;

    // configuration port shape
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 5;

    // bits per byte before the acknowledge clock
    localparam logic [BIT_COUNT_WIDTH-1:0] BYTE_BITS = 4'd8;

    // reset values of the line positions
    localparam logic [LINE_POS_WIDTH-1:0] CLOCK_LINE_RESET = 5'd0;
    localparam logic [LINE_POS_WIDTH-1:0] DATA_LINE_RESET  = 5'd1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_CLOCK_LINE_BIT = 1'b0,
        CFG_DATA_LINE_BIT  = 1'b1
    } cfg_reg_t;

    // token kinds
    typedef enum logic [1:0] {
        TOKEN_START = 2'd0,
        TOKEN_STOP  = 2'd1,
        TOKEN_ADDR  = 2'd2,
        TOKEN_DATA  = 2'd3
    } token_kind_t;

endpackage

>>> rtl/core/i2cm_sample_if.sv
interface i2cm_sample_if;

    logic                                 valid;
    logic                                 ready;
    logic                                 restart;
    logic [i2cm_pkg::LEVELS_WIDTH-1:0]    levels;
    logic [i2cm_pkg::TIME_WIDTH-1:0]      sample_time;

    modport source (
        output valid, restart, levels, sample_time,
        input  ready
    );

    modport sink (
        input  valid, restart, levels, sample_time,
        output ready
    );

endinterface

>>> rtl/core/i2cm_token_if.sv
interface i2cm_token_if;

    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           token_kind;
    logic [i2cm_pkg::BYTE_WIDTH-1:0]      byte_value;
    logic                                 read_flag;
    logic                                 acked;
    logic [i2cm_pkg::TIME_WIDTH-1:0]      token_time;

    modport source (
        output valid, token_kind, byte_value, read_flag, acked, token_time,
        input  ready
    );

    modport sink (
        input  valid, token_kind, byte_value, read_flag, acked, token_time,
        output ready
    );

endinterface

>>> rtl/core/i2c_bus_monitor_decoder.sv
// Passive I2C bus monitor.
// The sample channel carries one word of sampled line levels with its
// timestamp and a restart flag; the token channel returns START, STOP,
// address and data tokens. Both are valid/ready channels.
// SCL and SDA positions inside the level word are set through the write
// port (cfg_we, cfg_index, cfg_data); write them only while the block idles.
// A sample goes into an input register, is decoded against the bus state in
// one pass of edge logic and its token, if any, lands in the result register,
// which drives the token channel.
// One sample is taken every cycle; the result register lets the next sample
// be decoded while a token waits, and only a sample that makes a new token
// while the result register is still full holds the input register.
// When the token receiver stalls, a sample that makes a token waits in the
// input register and sample.ready drops until the waiting token is taken.
// Reset clears both registers, the bus state (both lines high, no transfer)
// and puts SCL at bit 0 and SDA at bit 1.
module i2c_bus_monitor_decoder #(
    parameter int LEVEL_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    i2cm_sample_if.sink                            sample,
    i2cm_token_if.source                           token,
    input  logic                                   cfg_we,
    input  logic [i2cm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    // configuration registers
    logic [i2cm_pkg::LINE_POS_WIDTH-1:0] clock_line_bit_reg;
    logic [i2cm_pkg::LINE_POS_WIDTH-1:0] data_line_bit_reg;

    // input register
    logic                                s1_valid_reg;
    logic                                s1_restart_reg;
    logic [i2cm_pkg::LEVELS_WIDTH-1:0]   s1_levels_reg;
    logic [i2cm_pkg::TIME_WIDTH-1:0]     s1_time_reg;

    // bus decoder state
    logic                                last_clock_reg,   last_clock_next;
    logic                                last_data_reg,    last_data_next;
    logic                                in_transfer_reg,  in_transfer_next;
    logic [i2cm_pkg::BIT_COUNT_WIDTH-1:0] bit_count_reg,   bit_count_next;
    logic [i2cm_pkg::BYTE_WIDTH-1:0]     shift_byte_reg,   shift_byte_next;
    logic                                address_done_reg, address_done_next;

    // result register
    logic                                out_valid_reg;
    i2cm_pkg::token_kind_t               out_kind_reg,     out_kind_next;
    logic [i2cm_pkg::BYTE_WIDTH-1:0]     out_byte_reg,     out_byte_next;
    logic                                out_read_reg,     out_read_next;
    logic                                out_ack_reg,      out_ack_next;
    logic [i2cm_pkg::TIME_WIDTH-1:0]     out_time_reg;

    logic                                pscl;
    logic                                psda;
    logic                                p_in_transfer;
    logic [i2cm_pkg::BIT_COUNT_WIDTH-1:0] p_bit_count;
    logic [i2cm_pkg::BYTE_WIDTH-1:0]     p_shift_byte;
    logic                                p_address_done;
    logic                                scl;
    logic                                sda;
    logic                                emit;
    logic                                out_free;
    logic                                advance;
    logic                                out_load;
    logic                                in_accept;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_line_bit_reg <= i2cm_pkg::CLOCK_LINE_RESET;
            data_line_bit_reg  <= i2cm_pkg::DATA_LINE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (i2cm_pkg::cfg_reg_t'(cfg_index))
                i2cm_pkg::CFG_CLOCK_LINE_BIT: clock_line_bit_reg <= cfg_data;
                i2cm_pkg::CFG_DATA_LINE_BIT:  data_line_bit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake between stages
    assign out_free  = !out_valid_reg || token.ready;
    assign advance   = s1_valid_reg && (!emit || out_free);
    assign out_load  = advance && emit;
    assign sample.ready = !s1_valid_reg || advance;
    assign in_accept = sample.valid && sample.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_restart_reg <= sample.restart;
            s1_levels_reg  <= sample.levels;
            s1_time_reg    <= sample.sample_time;
        end
    end

    // line extraction, positions past the probed width read low
    assign scl = s1_levels_reg[clock_line_bit_reg]
                 && (int'(clock_line_bit_reg) < LEVEL_WIDTH);
    assign sda = s1_levels_reg[data_line_bit_reg]
                 && (int'(data_line_bit_reg) < LEVEL_WIDTH);

    // prior state, cleared by restart
    always_comb
    begin
        if (s1_restart_reg)
        begin
            pscl           = 1'b1;
            psda           = 1'b1;
            p_in_transfer  = 1'b0;
            p_bit_count    = '0;
            p_shift_byte   = '0;
            p_address_done = 1'b0;
        end
        else
        begin
            pscl           = last_clock_reg;
            psda           = last_data_reg;
            p_in_transfer  = in_transfer_reg;
            p_bit_count    = bit_count_reg;
            p_shift_byte   = shift_byte_reg;
            p_address_done = address_done_reg;
        end
    end

    // bus event decode
    always_comb
    begin
        last_clock_next   = scl;
        last_data_next    = sda;
        in_transfer_next  = p_in_transfer;
        bit_count_next    = p_bit_count;
        shift_byte_next   = p_shift_byte;
        address_done_next = p_address_done;
        emit              = 1'b0;
        out_kind_next     = i2cm_pkg::TOKEN_START;
        out_byte_next     = '0;
        out_read_next     = 1'b0;
        out_ack_next      = 1'b0;

        if (pscl && scl && (sda != psda))
        begin
            emit = 1'b1;
            if (psda)
            begin
                // start or repeated start
                out_kind_next     = i2cm_pkg::TOKEN_START;
                in_transfer_next  = 1'b1;
                bit_count_next    = '0;
                shift_byte_next   = '0;
                address_done_next = 1'b0;
            end
            else
            begin
                out_kind_next    = i2cm_pkg::TOKEN_STOP;
                in_transfer_next = 1'b0;
            end
        end
        else if (!pscl && scl && p_in_transfer)
        begin
            if (p_bit_count < i2cm_pkg::BYTE_BITS)
            begin
                // shift one data bit in
                shift_byte_next = {p_shift_byte[i2cm_pkg::BYTE_WIDTH-2:0], sda};
                bit_count_next  = p_bit_count + 1'b1;
            end
            else
            begin
                // acknowledge clock closes the byte
                emit         = 1'b1;
                out_ack_next = !sda;
                if (!p_address_done)
                begin
                    out_kind_next = i2cm_pkg::TOKEN_ADDR;
                    out_byte_next = {1'b0, p_shift_byte[i2cm_pkg::BYTE_WIDTH-1:1]};
                    out_read_next = p_shift_byte[0];
                end
                else
                begin
                    out_kind_next = i2cm_pkg::TOKEN_DATA;
                    out_byte_next = p_shift_byte;
                end
                bit_count_next    = '0;
                shift_byte_next   = '0;
                address_done_next = 1'b1;
            end
        end
    end

    // bus state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_clock_reg   <= 1'b1;
            last_data_reg    <= 1'b1;
            in_transfer_reg  <= 1'b0;
            bit_count_reg    <= '0;
            shift_byte_reg   <= '0;
            address_done_reg <= 1'b0;
        end
        else if (advance)
        begin
            last_clock_reg   <= last_clock_next;
            last_data_reg    <= last_data_next;
            in_transfer_reg  <= in_transfer_next;
            bit_count_reg    <= bit_count_next;
            shift_byte_reg   <= shift_byte_next;
            address_done_reg <= address_done_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (token.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg <= out_kind_next;
            out_byte_reg <= out_byte_next;
            out_read_reg <= out_read_next;
            out_ack_reg  <= out_ack_next;
            out_time_reg <= s1_time_reg;
        end
    end

    // token word
    assign token.valid      = out_valid_reg;
    assign token.token_kind = out_kind_reg;
    assign token.byte_value = out_byte_reg;
    assign token.read_flag  = out_read_reg;
    assign token.acked      = out_ack_reg;
    assign token.token_time = out_time_reg;

`ifndef SYNTHESIS
    // bit counter stops at the acknowledge clock
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= i2cm_pkg::BYTE_BITS)
    else $error("bit counter past acknowledge clock");

    // a start token opens a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_kind_next == i2cm_pkg::TOKEN_START) |=> in_transfer_reg)
    else $error("start token without transfer");

    // a stop token closes the transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_kind_next == i2cm_pkg::TOKEN_STOP) |=> !in_transfer_reg)
    else $error("stop token left transfer open");

    // after an address or data token the address phase is over
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (out_kind_next == i2cm_pkg::TOKEN_ADDR
                   || out_kind_next == i2cm_pkg::TOKEN_DATA))
        |=> (address_done_reg && bit_count_reg == '0))
    else $error("byte token did not close the byte");
`endif

endmodule

>>> tb/sv/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam int LEVEL_WIDTH = 32;
    // cycles the token path may still be busy after the last token left
    localparam int IDLE_TAIL   = 8;
    localparam int PHASES      = 7;

    typedef struct {
        token_kind_t               kind;
        logic [BYTE_WIDTH-1:0]     value;
        logic                      rd;
        logic                      ack;
        logic [TIME_WIDTH-1:0]     stamp;
    } token_t;

    typedef enum {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_TOKEN
    } row_check_t;

    typedef struct {
        logic                      rs;
        logic                      scl;
        logic                      sda;
        logic [LEVELS_WIDTH-1:0]   fill;
        logic [TIME_WIDTH-1:0]     stamp;
        row_check_t                chk;
        token_t                    want;
    } row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [CFG_INDEX_WIDTH-1:0]    cfg_index;
    logic [CFG_DATA_WIDTH-1:0]     cfg_data;

    i2cm_sample_if sample_ch();
    i2cm_token_if  token_ch();

    i2c_bus_monitor_decoder #(
        .LEVEL_WIDTH(LEVEL_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .token    (token_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // decoder copy: line positions and bus state
    logic [LINE_POS_WIDTH-1:0]     line_clk;
    logic [LINE_POS_WIDTH-1:0]     line_dat;
    logic                          bus_scl;
    logic                          bus_sda;
    logic                          in_xfer;
    logic [BIT_COUNT_WIDTH-1:0]    bits_seen;
    logic [BYTE_WIDTH-1:0]         shift_reg;
    logic                          addr_seen;

    token_t                        pending_tokens[$];
    row_t                          stim_rows[$];
    token_t                        no_token;
    int                            mismatch_count = 0;
    int                            word_count;
    int                            src_calm = 0;
    int                            rdy_calm = 0;
    int                            rdy_hold = 0;
    // line pair last put on the bus by the stimulus
    logic                          cur_scl;
    logic                          cur_sda;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("i2c_bus_monitor_decoder regression: fail");
        $finish;
    end

    function automatic void clear_bus();
        bus_scl   = 1'b1;
        bus_sda   = 1'b1;
        in_xfer   = 1'b0;
        bits_seen = '0;
        shift_reg = '0;
        addr_seen = 1'b0;
    endfunction

    // a line past the probed width reads low
    function automatic logic line_at(input logic [LEVELS_WIDTH-1:0] lv,
                                     input logic [LINE_POS_WIDTH-1:0] pos);
        if (pos >= LEVEL_WIDTH)
            return 1'b0;
        return lv[pos];
    endfunction

    // one sample through the edge logic; returns 1 when a token comes out
    function automatic bit decode_sample(input logic rs,
                                         input logic [LEVELS_WIDTH-1:0] lv,
                                         input logic [TIME_WIDTH-1:0] stamp,
                                         output token_t tok);
        logic scl;
        logic sda;
        bit   made;
        made = 1'b0;
        tok  = '{kind: TOKEN_START, value: '0, rd: 1'b0, ack: 1'b0, stamp: stamp};
        if (rs)
            clear_bus();
        scl = line_at(lv, line_clk);
        sda = line_at(lv, line_dat);
        // sda moving under a high clock: start or stop
        if (bus_scl && scl && sda != bus_sda)
        begin
            made = 1'b1;
            if (bus_sda)
            begin
                tok.kind  = TOKEN_START;
                in_xfer   = 1'b1;
                bits_seen = '0;
                shift_reg = '0;
                addr_seen = 1'b0;
            end
            else
            begin
                tok.kind = TOKEN_STOP;
                in_xfer  = 1'b0;
            end
        end
        // rising clock inside a transfer: shift a bit or close the byte
        else if (!bus_scl && scl && in_xfer)
        begin
            if (bits_seen < BYTE_BITS)
            begin
                shift_reg = {shift_reg[BYTE_WIDTH-2:0], sda};
                bits_seen = bits_seen + 1'b1;
            end
            else
            begin
                made    = 1'b1;
                tok.ack = ~sda;
                if (!addr_seen)
                begin
                    tok.kind  = TOKEN_ADDR;
                    tok.value = {1'b0, shift_reg[BYTE_WIDTH-1:1]};
                    tok.rd    = shift_reg[0];
                end
                else
                begin
                    tok.kind  = TOKEN_DATA;
                    tok.value = shift_reg;
                end
                bits_seen = '0;
                shift_reg = '0;
                addr_seen = 1'b1;
            end
        end
        bus_scl = scl;
        bus_sda = sda;
        return made;
    endfunction

    // gap length: mostly none, some short, a few long, now and then a calm stretch
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LEVELS_WIDTH-1:0] put_lines(input logic [LEVELS_WIDTH-1:0] fill,
                                                          input logic s, input logic d);
        logic [LEVELS_WIDTH-1:0] w;
        w           = fill;
        w[line_dat] = d;
        w[line_clk] = s;
        return w;
    endfunction

    function automatic void add_row(input logic rs, input logic scl, input logic sda,
                                    input logic [LEVELS_WIDTH-1:0] fill,
                                    input logic [TIME_WIDTH-1:0] stamp,
                                    input row_check_t chk, input token_kind_t kind,
                                    input logic [BYTE_WIDTH-1:0] value,
                                    input logic rd, input logic ack);
        row_t r;
        r.rs    = rs;
        r.scl   = scl;
        r.sda   = sda;
        r.fill  = fill;
        r.stamp = stamp;
        r.chk   = chk;
        r.want  = '{kind: kind, value: value, rd: rd, ack: ack, stamp: stamp};
        stim_rows.push_back(r);
    endfunction

    // present one sample word, wait for it to be taken, predict, then maybe idle
    task automatic send_sample(input logic rs, input logic [LEVELS_WIDTH-1:0] lv,
                               input logic [TIME_WIDTH-1:0] stamp,
                               input row_check_t chk, input token_t want);
        token_t tok;
        bit     made;
        int     gap;
        sample_ch.valid       <= 1'b1;
        sample_ch.restart     <= rs;
        sample_ch.levels      <= lv;
        sample_ch.sample_time <= stamp;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        made = decode_sample(rs, lv, stamp, tok);
        if (chk == ROW_TOKEN)
            pending_tokens.push_back(want);
        else if (chk == ROW_PREDICT && made)
            pending_tokens.push_back(tok);
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drop valid and hold off until every predicted token has come back
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tokens.size() != 0);
    endtask

    task automatic load_lines(input logic [LINE_POS_WIDTH-1:0] c,
                              input logic [LINE_POS_WIDTH-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CLOCK_LINE_BIT;
        cfg_data  <= c;
        @(posedge clk);
        cfg_index <= CFG_DATA_LINE_BIT;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we   <= 1'b0;
        line_clk  = c;
        line_dat  = d;
    endtask

    // put a line pair on the bus, other probed lines random, sometimes held a while
    task automatic bus_to(input logic rs, input logic s, input logic d);
        int extra;
        if (rs || s != cur_scl || d != cur_sda)
            word_count++;
        cur_scl = s;
        cur_sda = d;
        send_sample(rs, put_lines($urandom, s, d), $urandom, ROW_PREDICT, no_token);
        if ($urandom_range(0, 99) < 8)
        begin
            extra = $urandom_range(1, 3);
            repeat (extra)
                send_sample(1'b0, put_lines($urandom, s, d), $urandom, ROW_PREDICT, no_token);
        end
    endtask

    // start, or repeated start when the bus is not idle
    task automatic go_start();
        if (!(cur_scl && cur_sda))
        begin
            bus_to(1'b0, 1'b0, 1'b1);
            bus_to(1'b0, 1'b1, 1'b1);
        end
        bus_to(1'b0, 1'b1, 1'b0);
    endtask

    task automatic stop_bus();
        bus_to(1'b0, 1'b0, 1'b0);
        bus_to(1'b0, 1'b1, 1'b0);
        bus_to(1'b0, 1'b1, 1'b1);
    endtask

    // clock out the top nbits of a byte, msb first; a full byte gets its ack clock
    task automatic clock_byte(input logic [BYTE_WIDTH-1:0] b, input int nbits);
        int   i;
        logic sda_ack;
        for (i = BYTE_WIDTH - 1; i > BYTE_WIDTH - 1 - nbits; i--)
        begin
            bus_to(1'b0, 1'b0, b[i]);
            bus_to(1'b0, 1'b1, b[i]);
        end
        if (nbits == BYTE_WIDTH)
        begin
            sda_ack = ($urandom_range(0, 3) == 0);
            bus_to(1'b0, 1'b0, sda_ack);
            bus_to(1'b0, 1'b1, sda_ack);
        end
    endtask

    // address byte and a few data bytes, now and then cut short
    task automatic run_transfer();
        int nbytes;
        int k;
        int pick;
        go_start();
        nbytes = $urandom_range(1, 5);
        for (k = 0; k < nbytes; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                clock_byte(BYTE_WIDTH'($urandom), $urandom_range(1, 7));
                break;
            end
            if (pick < 8)
            begin
                bus_to(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                break;
            end
            clock_byte(BYTE_WIDTH'($urandom), BYTE_WIDTH);
        end
        // otherwise the next transfer opens with a repeated start
        if ($urandom_range(0, 99) < 70)
            stop_bus();
    endtask

    // token receiver: ready idles in random stretches
    always @(posedge clk)
    begin
        if (!rst_n)
            token_ch.ready <= 1'b0;
        else if (rdy_hold > 0)
            rdy_hold <= rdy_hold - 1;
        else
        begin
            int low;
            low = pick_gap(rdy_calm);
            if (low > 0)
            begin
                token_ch.ready <= 1'b0;
                rdy_hold       <= low - 1;
            end
            else
            begin
                token_ch.ready <= 1'b1;
                rdy_hold       <= $urandom_range(0, 6);
            end
        end
    end

    // compare each accepted token with the oldest prediction
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && token_ch.valid && token_ch.ready)
        begin
            if (pending_tokens.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected token kind %0d byte %02h rd %0b ack %0b time %08h",
                         $realtime, token_ch.token_kind, token_ch.byte_value,
                         token_ch.read_flag, token_ch.acked, token_ch.token_time);
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (token_ch.token_kind !== want.kind || token_ch.byte_value !== want.value ||
                    token_ch.read_flag !== want.rd || token_ch.acked !== want.ack ||
                    token_ch.token_time !== want.stamp)
                begin
                    mismatch_count++;
                    $display("%0t: token mismatch: expected kind %0d byte %02h rd %0b ack %0b time %08h",
                             $realtime, want.kind, want.value, want.rd, want.ack, want.stamp);
                    $display("%0t: token mismatch:   actual kind %0d byte %02h rd %0b ack %0b time %08h",
                             $realtime, token_ch.token_kind, token_ch.byte_value,
                             token_ch.read_flag, token_ch.acked, token_ch.token_time);
                end
            end
        end
    end

    // main sequence
    initial
    begin
        int                        n;
        int                        ph;
        int                        k;
        int                        burst;
        int                        pick;
        logic [LINE_POS_WIDTH-1:0] phase_clk[PHASES];
        logic [LINE_POS_WIDTH-1:0] phase_dat[PHASES];
        int                        phase_words[PHASES];

        // extremes, swapped lines and both lines on one bit
        phase_clk   = '{5'd0, 5'd31, 5'd17, 5'd0,  5'd31, 5'd12, 5'd6};
        phase_dat   = '{5'd1, 5'd0,  5'd5,  5'd31, 5'd31, 5'd12, 5'd29};
        phase_words = '{180,  120,   120,   110,   40,    30,    140};

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_CLOCK_LINE_BIT;
        cfg_data              = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.restart     = 1'b0;
        sample_ch.levels      = '0;
        sample_ch.sample_time = '0;
        no_token = '{kind: TOKEN_START, value: '0, rd: 1'b0, ack: 1'b0, stamp: '0};
        line_clk = CLOCK_LINE_RESET;
        line_dat = DATA_LINE_RESET;
        clear_bus();
        cur_scl  = 1'b1;
        cur_sda  = 1'b1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: address 0x52 read, acked, framed by start and stop; restart cases
        add_row(1, 1, 1, 32'hFFFF_FFFF, 32'h0000_0000, ROW_QUIET, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 0, 32'hA5A5_A5A5, 32'hFFFF_FFFF, ROW_TOKEN, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 0, 1, 32'h0000_0000, 32'h0000_0010, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 1, 32'hFFFF_FFFF, 32'h0000_0011, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 0, 0, 32'h5555_5555, 32'h0000_0012, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 0, 32'hAAAA_AAAA, 32'h0000_0013, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 0, 1, 32'h0F0F_0F0F, 32'h0000_0014, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 1, 32'hF0F0_F0F0, 32'h0000_0015, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 0, 0, 32'h3333_3333, 32'h0000_0016, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 0, 32'hCCCC_CCCC, 32'h0000_0017, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 0, 0, 32'h00FF_00FF, 32'h0000_0018, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 0, 32'hFF00_FF00, 32'h0000_0019, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 0, 1, 32'h8000_0000, 32'h0000_001A, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 1, 32'h7FFF_FFFF, 32'h0000_001B, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 0, 0, 32'h1234_5678, 32'h0000_001C, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 0, 32'h9ABC_DEF0, 32'h0000_001D, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 0, 1, 32'hDEAD_BEEF, 32'h0000_001E, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 1, 32'h0BAD_F00D, 32'h0000_001F, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 0, 0, 32'hFFFF_0000, 32'h0000_0020, ROW_PREDICT, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 0, 32'h0000_FFFF, 32'h8000_0000, ROW_TOKEN, TOKEN_ADDR, 8'h52, 1, 1);
        add_row(0, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ROW_TOKEN, TOKEN_STOP, 8'h00, 0, 0);
        add_row(1, 0, 0, 32'h0000_0000, 32'h0000_0000, ROW_QUIET, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 1, 32'h0000_0000, 32'h0000_0001, ROW_QUIET, TOKEN_START, 8'h00, 0, 0);
        add_row(1, 1, 0, 32'h6666_6666, 32'h7FFF_FFFF, ROW_TOKEN, TOKEN_START, 8'h00, 0, 0);
        add_row(0, 1, 1, 32'h9999_9999, 32'hFFFF_FFFE, ROW_TOKEN, TOKEN_STOP, 8'h00, 0, 0);

        for (n = 0; n < stim_rows.size(); n++)
            send_sample(stim_rows[n].rs,
                        put_lines(stim_rows[n].fill, stim_rows[n].scl, stim_rows[n].sda),
                        stim_rows[n].stamp, stim_rows[n].chk, stim_rows[n].want);
        cur_scl = 1'b1;
        cur_sda = 1'b1;

        // random transfers under each line setting
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            repeat (IDLE_TAIL) @(posedge clk);
            load_lines(phase_clk[ph], phase_dat[ph]);
            word_count = 0;
            bus_to(1'b1, 1'b1, 1'b1);
            while (word_count < phase_words[ph])
            begin
                pick = $urandom_range(0, 99);
                if (pick < 82)
                    run_transfer();
                else if (pick < 96)
                begin
                    // noise: random line pairs, occasional restart
                    burst = $urandom_range(1, 6);
                    for (k = 0; k < burst; k++)
                        bus_to($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                end
                else if (pick < 98)
                    wait_drained();
                else
                    bus_to(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end

        wait_drained();
        repeat (IDLE_TAIL) @(posedge clk);
        if (mismatch_count == 0)
            $display("i2c_bus_monitor_decoder regression: pass");
        else
            $display("i2c_bus_monitor_decoder regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_sample_if.sv
rtl/core/i2cm_token_if.sv
rtl/core/i2c_bus_monitor_decoder.sv
tb/sv/tb.sv
